@@ rtl/iorr_pkg.sv @@
// Shared types, codes and constants of the diagnostic request receiver.
package iorr_pkg;

    localparam int BUFFER_BYTES_DEF = 256;
    localparam int MAX_CHUNKS       = 32;

    localparam logic [1:0] REQ_NEW   = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [2:0] KIND_REQUEST = 3'd0;
    localparam logic [2:0] KIND_FLOW    = 3'd1;
    localparam logic [2:0] KIND_CHUNK   = 3'd2;
    localparam logic [2:0] KIND_BUSY    = 3'd3;
    localparam logic [2:0] KIND_INVALID = 3'd4;
    localparam logic [2:0] KIND_NODATA  = 3'd5;
    localparam logic [2:0] KIND_FULL    = 3'd6;

    localparam logic [2:0] CFG_REQUEST_ID = 3'd0;
    localparam logic [2:0] CFG_FILTER     = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd2;
    localparam logic [2:0] CFG_FC_ENABLE  = 3'd3;
    localparam logic [2:0] CFG_FC_MODE    = 3'd4;
    localparam logic [2:0] CFG_FC_ID      = 3'd5;

    localparam logic [3:0] PCI_SINGLE = 4'd0;
    localparam logic [3:0] PCI_FIRST  = 4'd1;
    localparam logic [3:0] PCI_CONSEC = 4'd2;

    localparam logic [10:0] RESP_LOW       = 11'h7E8;
    localparam logic [10:0] RESP_HIGH      = 11'h7EF;
    localparam logic [10:0] REQ_ID_RESET   = 11'h7DF;
    localparam logic [12:0] TIMEOUT_RESET  = 13'd1000;
    localparam logic [12:0] ELAPSED_MAX    = 13'h1FFF;
    localparam logic [7:0]  NEG_SID        = 8'h7F;
    localparam logic [7:0]  RESP_PENDING   = 8'h78;
    localparam logic [7:0]  POS_OFFSET     = 8'h40;
    localparam logic [7:0]  FC_CTS         = 8'h30;

    typedef struct packed {
        logic load;
        logic eval;
        logic write_step;
        logic proc;
        logic read_step;
        logic next_chunk;
    } iorr_cmd_t;

    typedef struct packed {
        logic wr_busy;
        logic res_ready;
        logic deliver;
        logic deliver_frame;
        logic read_done;
        logic more_chunks;
    } iorr_stat_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] nb);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < nb) m[8*i +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

@@ rtl/iorr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module iorr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/iorr_ctrl.sv @@
// Sequencing state machine of the diagnostic request receiver.
module iorr_ctrl import iorr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  iorr_stat_t stat,
    output iorr_cmd_t  cmd
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_PROC  = 6'b001000,
        ST_READ  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (stat.wr_busy) cmd.write_step = 1'b1;
                else state_next = ST_PROC;
            end
            ST_PROC: begin
                cmd.proc = 1'b1;
                if (stat.res_ready) state_next = ST_EMIT;
                else if (stat.deliver) begin
                    state_next = stat.deliver_frame ? ST_EMIT : ST_READ;
                end else state_next = ST_IDLE;
            end
            ST_READ: begin
                cmd.read_step = 1'b1;
                if (stat.read_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (stat.more_chunks) begin
                        cmd.next_chunk = 1'b1;
                        state_next     = ST_READ;
                    end else state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

@@ rtl/iorr_datapath.sv @@
// Registers, reassembly store and message logic of the diagnostic request receiver.
module iorr_datapath import iorr_pkg::*; #(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    input  logic [1:0]  in_type,
    input  logic [10:0] in_id,
    input  logic [3:0]  in_cnt,
    input  logic [63:0] in_data,
    input  iorr_cmd_t   cmd,
    output iorr_stat_t  stat,
    output logic [2:0]  out_kind,
    output logic [10:0] out_id,
    output logic [11:0] out_len,
    output logic [63:0] out_data,
    output logic [3:0]  out_nb,
    output logic        out_neg,
    output logic        out_last
);
    localparam int AW = $clog2(BUFFER_BYTES);

    logic [10:0] req_id_reg, req_id_next, filt_reg, filt_next, fc_id_reg, fc_id_next;
    logic [12:0] tmo_reg, tmo_next;
    logic        fc_en_reg, fc_en_next, fc_mode_reg, fc_mode_next;

    logic [1:0]  in_type_reg, in_type_next;
    logic [10:0] in_id_reg, in_id_next;
    logic [3:0]  in_cnt_reg, in_cnt_next;
    logic [63:0] in_data_reg, in_data_next;

    logic        pend_reg, pend_next, has_pid_reg, has_pid_next;
    logic [7:0]  svc_reg, svc_next, pid_reg, pid_next;
    logic [12:0] elapsed_reg, elapsed_next;
    logic [11:0] exp_reg, exp_next, recv_reg, recv_next;
    logic [3:0]  nseq_reg, nseq_next;
    logic [10:0] src_id_reg, src_id_next;

    logic        res_reg, res_next, proc_reg, proc_next, frame_reg, frame_next;
    logic [11:0] msg_len_reg, msg_len_next;
    logic [3:0]  wr_left_reg, wr_left_next;
    logic [11:0] wr_addr_reg, wr_addr_next;
    logic [2:0]  wr_src_reg, wr_src_next;
    logic [7:0]  head0_reg, head0_next, head1_reg, head1_next, head2_reg, head2_next;
    logic [4:0]  idx_reg, idx_next, last_idx_reg, last_idx_next;
    logic [3:0]  rd_cnt_reg, rd_cnt_next;

    logic [2:0]  kind_reg, kind_next;
    logic [10:0] oid_reg, oid_next;
    logic [11:0] olen_reg, olen_next;
    logic [63:0] odata_reg, odata_next;
    logic [3:0]  onb_reg, onb_next;
    logic        oneg_reg, oneg_next, olast_reg, olast_next;

    logic [7:0]  b0, b1, svc_in, m0, m1, m2, wr_byte, ram_rdata;
    logic [3:0]  len8, pl, lm1, n_ff, amount, nb_next_chunk;
    logic [11:0] avail, recv_sum, rem, rem_next, lm;
    logic [11:0] rd_addr_full;
    logic [12:0] el_inc;
    logic [4:0]  idx_inc;
    logic [2:0]  cap_pos;
    logic [63:0] req_mask;
    logic        svc_ok, frame_ok, neg, deliver, resp_pend;

    iorr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
        .aclk  (aclk),
        .we    (cmd.write_step),
        .waddr (wr_addr_reg[AW-1:0]),
        .wdata (wr_byte),
        .raddr (rd_addr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign b0       = in_data_reg[7:0];
    assign b1       = in_data_reg[15:8];
    assign svc_in   = b0;
    assign len8     = (in_cnt_reg > 4'd8) ? 4'd8 : in_cnt_reg;
    assign lm1      = len8 - 4'd1;
    assign pl       = (b0[3:0] > lm1) ? lm1 : b0[3:0];
    assign n_ff     = ({8'b0, len8 - 4'd2} > {b0[3:0], b1}) ? b1[3:0] : (len8 - 4'd2);
    assign avail    = exp_reg - recv_reg;
    assign amount   = ({8'b0, lm1} > avail) ? avail[3:0] : lm1;
    assign recv_sum = recv_reg + {8'b0, amount};
    assign el_inc   = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 13'd1;
    assign wr_byte  = in_data_reg[8*wr_src_reg +: 8];
    assign rd_addr_full = {4'b0, idx_reg, 3'b0} + {9'b0, rd_cnt_reg[2:0]};
    assign idx_inc  = idx_reg + 5'd1;
    assign rem      = msg_len_reg;
    assign rem_next = olen_reg - {4'b0, idx_inc, 3'b0};
    assign nb_next_chunk = (rem_next > 12'd8) ? 4'd8 : rem_next[3:0];
    assign lm       = msg_len_reg - 12'd1;
    assign cap_pos  = 3'(rd_cnt_reg - 4'd1);
    assign req_mask = byte_mask(in_cnt_reg);

    assign svc_ok = (svc_in == 8'h01) || (svc_in == 8'h02) || (svc_in == 8'h03) ||
                    (svc_in == 8'h04) || (svc_in == 8'h07) || (svc_in == 8'h09) ||
                    (svc_in == 8'h0A);
    assign frame_ok = pend_reg && (in_id_reg >= RESP_LOW) && (in_id_reg <= RESP_HIGH) &&
                      (len8 >= 4'd2) && ((filt_reg == 11'd0) || (in_id_reg == filt_reg));

    assign m0 = frame_reg ? in_data_reg[15:8]  : head0_reg;
    assign m1 = frame_reg ? in_data_reg[23:16] : head1_reg;
    assign m2 = frame_reg ? in_data_reg[31:24] : head2_reg;
    assign neg = (m0 == NEG_SID);
    assign resp_pend = neg && (msg_len_reg >= 12'd3) && (m2 == RESP_PENDING);
    assign deliver = proc_reg && (neg ? !resp_pend :
                     (pend_reg && (m0 == svc_reg + POS_OFFSET) &&
                      !(has_pid_reg && (msg_len_reg > 12'd1) && (m1 != pid_reg))));

    always_comb begin
        stat.wr_busy       = (wr_left_reg != 4'd0);
        stat.res_ready     = res_reg;
        stat.deliver       = deliver;
        stat.deliver_frame = frame_reg;
        stat.read_done     = (rd_cnt_reg == 4'd8);
        stat.more_chunks   = (kind_reg == KIND_CHUNK) && !olast_reg;
    end

    always_comb begin
        req_id_next = req_id_reg; filt_next = filt_reg; tmo_next = tmo_reg;
        fc_en_next = fc_en_reg; fc_mode_next = fc_mode_reg; fc_id_next = fc_id_reg;
        in_type_next = in_type_reg; in_id_next = in_id_reg;
        in_cnt_next = in_cnt_reg; in_data_next = in_data_reg;
        pend_next = pend_reg; svc_next = svc_reg; has_pid_next = has_pid_reg;
        pid_next = pid_reg; elapsed_next = elapsed_reg; exp_next = exp_reg;
        recv_next = recv_reg; nseq_next = nseq_reg; src_id_next = src_id_reg;
        res_next = res_reg; proc_next = proc_reg; frame_next = frame_reg;
        msg_len_next = msg_len_reg; wr_left_next = wr_left_reg;
        wr_addr_next = wr_addr_reg; wr_src_next = wr_src_reg;
        head0_next = head0_reg; head1_next = head1_reg; head2_next = head2_reg;
        idx_next = idx_reg; last_idx_next = last_idx_reg; rd_cnt_next = rd_cnt_reg;
        kind_next = kind_reg; oid_next = oid_reg; olen_next = olen_reg;
        odata_next = odata_reg; onb_next = onb_reg; oneg_next = oneg_reg;
        olast_next = olast_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_REQUEST_ID: req_id_next  = cfg_wdata[10:0];
                CFG_FILTER:     filt_next    = cfg_wdata[10:0];
                CFG_TIMEOUT:    tmo_next     = cfg_wdata;
                CFG_FC_ENABLE:  fc_en_next   = cfg_wdata[0];
                CFG_FC_MODE:    fc_mode_next = cfg_wdata[0];
                CFG_FC_ID:      fc_id_next   = cfg_wdata[10:0];
                default: ;
            endcase
        end

        if (cmd.load) begin
            in_type_next = in_type; in_id_next = in_id;
            in_cnt_next = in_cnt; in_data_next = in_data;
            res_next = 1'b0; proc_next = 1'b0; frame_next = 1'b0;
            wr_left_next = 4'd0;
        end

        if (cmd.eval) begin
            kind_next = KIND_BUSY; oid_next = '0; olen_next = '0; odata_next = '0;
            onb_next = '0; oneg_next = 1'b0; olast_next = 1'b1;
            case (in_type_reg)
                REQ_NEW: begin
                    res_next = 1'b1;
                    if (pend_reg) kind_next = KIND_BUSY;
                    else if (in_cnt_reg == 4'd0 || in_cnt_reg > 4'd7 || !svc_ok) begin
                        kind_next = KIND_INVALID;
                    end else begin
                        svc_next     = svc_in;
                        has_pid_next = (in_cnt_reg > 4'd1);
                        pid_next     = (in_cnt_reg > 4'd1) ? b1 : 8'd0;
                        pend_next    = 1'b1;
                        elapsed_next = '0;
                        exp_next     = '0;
                        recv_next    = '0;
                        nseq_next    = 4'd1;
                        kind_next    = KIND_REQUEST;
                        oid_next     = req_id_reg;
                        odata_next   = {in_data_reg[55:0] & req_mask[55:0],
                                        4'd0, in_cnt_reg};
                        onb_next     = 4'd8;
                    end
                end
                REQ_FRAME: begin
                    if (frame_ok) begin
                        case (b0[7:4])
                            PCI_SINGLE: begin
                                if (pl != 4'd0) begin
                                    proc_next    = 1'b1;
                                    frame_next   = 1'b1;
                                    msg_len_next = {8'b0, pl};
                                end
                            end
                            PCI_FIRST: begin
                                exp_next = {b0[3:0], b1};
                                if ({b0[3:0], b1} > 12'(BUFFER_BYTES)) begin
                                    pend_next = 1'b0;
                                    res_next  = 1'b1;
                                    kind_next = KIND_FULL;
                                end else begin
                                    src_id_next  = in_id_reg;
                                    wr_left_next = n_ff;
                                    wr_addr_next = '0;
                                    wr_src_next  = 3'd2;
                                    recv_next    = {8'b0, n_ff};
                                    nseq_next    = 4'd1;
                                    if (fc_en_reg) begin
                                        res_next   = 1'b1;
                                        kind_next  = KIND_FLOW;
                                        oid_next   = (fc_mode_reg && fc_id_reg != 11'd0) ?
                                                     fc_id_reg : in_id_reg - 11'd8;
                                        odata_next = {56'b0, FC_CTS};
                                        onb_next   = 4'd8;
                                    end
                                end
                            end
                            PCI_CONSEC: begin
                                if (in_id_reg == src_id_reg && exp_reg != 12'd0 &&
                                    b0[3:0] == nseq_reg) begin
                                    nseq_next    = nseq_reg + 4'd1;
                                    wr_left_next = amount;
                                    wr_addr_next = recv_reg;
                                    wr_src_next  = 3'd1;
                                    recv_next    = recv_sum;
                                    if (recv_sum >= exp_reg) begin
                                        proc_next    = 1'b1;
                                        msg_len_next = exp_reg;
                                        exp_next     = '0;
                                        recv_next    = '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                REQ_TICK: begin
                    if (pend_reg) begin
                        elapsed_next = el_inc;
                        if (el_inc >= tmo_reg) begin
                            pend_next = 1'b0;
                            res_next  = 1'b1;
                            kind_next = KIND_NODATA;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (cmd.write_step) begin
            if (wr_addr_reg == 12'd0) head0_next = wr_byte;
            if (wr_addr_reg == 12'd1) head1_next = wr_byte;
            if (wr_addr_reg == 12'd2) head2_next = wr_byte;
            wr_addr_next = wr_addr_reg + 12'd1;
            wr_src_next  = wr_src_reg + 3'd1;
            wr_left_next = wr_left_reg - 4'd1;
        end

        if (cmd.proc && proc_reg) begin
            if (resp_pend) elapsed_next = '0;
            if (deliver) begin
                pend_next     = 1'b0;
                kind_next     = KIND_CHUNK;
                oid_next      = in_id_reg;
                olen_next     = msg_len_reg;
                oneg_next     = neg;
                idx_next      = '0;
                last_idx_next = (lm[11:3] > 9'd31) ? 5'd31 : lm[7:3];
                olast_next    = (lm[11:3] == 9'd0);
                onb_next      = (rem > 12'd8) ? 4'd8 : rem[3:0];
                rd_cnt_next   = '0;
                odata_next    = frame_reg ?
                                ({8'b0, in_data_reg[63:8]} & byte_mask(msg_len_reg[3:0])) :
                                64'd0;
            end
        end

        if (cmd.read_step) begin
            if (rd_cnt_reg != 4'd8) rd_cnt_next = rd_cnt_reg + 4'd1;
            if (rd_cnt_reg != 4'd0 && {1'b0, cap_pos} < onb_reg) begin
                odata_next[8*cap_pos +: 8] = ram_rdata;
            end
        end

        if (cmd.next_chunk) begin
            idx_next    = idx_inc;
            onb_next    = nb_next_chunk;
            olast_next  = (idx_inc == last_idx_reg);
            odata_next  = '0;
            rd_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_id_reg  <= REQ_ID_RESET;
            filt_reg    <= '0;
            tmo_reg     <= TIMEOUT_RESET;
            fc_en_reg   <= 1'b1;
            fc_mode_reg <= 1'b0;
            fc_id_reg   <= '0;
            pend_reg    <= 1'b0;
            svc_reg     <= '0;
            has_pid_reg <= 1'b0;
            pid_reg     <= '0;
            elapsed_reg <= '0;
            exp_reg     <= '0;
            recv_reg    <= '0;
            nseq_reg    <= 4'd1;
            src_id_reg  <= '0;
            res_reg     <= 1'b0;
            proc_reg    <= 1'b0;
            frame_reg   <= 1'b0;
            wr_left_reg <= '0;
            rd_cnt_reg  <= '0;
            idx_reg     <= '0;
            last_idx_reg <= '0;
            kind_reg    <= KIND_BUSY;
            olast_reg   <= 1'b1;
        end else begin
            req_id_reg  <= req_id_next;
            filt_reg    <= filt_next;
            tmo_reg     <= tmo_next;
            fc_en_reg   <= fc_en_next;
            fc_mode_reg <= fc_mode_next;
            fc_id_reg   <= fc_id_next;
            pend_reg    <= pend_next;
            svc_reg     <= svc_next;
            has_pid_reg <= has_pid_next;
            pid_reg     <= pid_next;
            elapsed_reg <= elapsed_next;
            exp_reg     <= exp_next;
            recv_reg    <= recv_next;
            nseq_reg    <= nseq_next;
            src_id_reg  <= src_id_next;
            res_reg     <= res_next;
            proc_reg    <= proc_next;
            frame_reg   <= frame_next;
            wr_left_reg <= wr_left_next;
            rd_cnt_reg  <= rd_cnt_next;
            idx_reg     <= idx_next;
            last_idx_reg <= last_idx_next;
            kind_reg    <= kind_next;
            olast_reg   <= olast_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_type_reg <= in_type_next;
        in_id_reg   <= in_id_next;
        in_cnt_reg  <= in_cnt_next;
        in_data_reg <= in_data_next;
        msg_len_reg <= msg_len_next;
        wr_addr_reg <= wr_addr_next;
        wr_src_reg  <= wr_src_next;
        head0_reg   <= head0_next;
        head1_reg   <= head1_next;
        head2_reg   <= head2_next;
        oid_reg     <= oid_next;
        olen_reg    <= olen_next;
        odata_reg   <= odata_next;
        onb_reg     <= onb_next;
        oneg_reg    <= oneg_next;
    end

    assign out_kind = kind_reg;
    assign out_id   = oid_reg;
    assign out_len  = olen_reg;
    assign out_data = odata_reg;
    assign out_nb   = onb_reg;
    assign out_neg  = oneg_reg;
    assign out_last = olast_reg;
endmodule

@@ rtl/isotp_obd_request_receiver_top.sv @@
// Top level of the diagnostic request receiver with transport-layer reassembly.
// The slave channel takes one request at a time: a new diagnostic request, a
// received CAN frame or a one millisecond tick, selected by s_tuser. The master
// channel returns the resulting items: request frames, flow control frames,
// message chunks of up to eight bytes, or busy, invalid, no-data and buffer-full
// notices; m_tlast marks the final item caused by one request.
// A request that yields a single item passes through the evaluate, write and
// process states after acceptance and then presents the item. A first or
// consecutive frame stays in the write state while its bytes go into the store.
// Each chunk of a delivered multi-frame message is read from the store one byte
// per cycle, since the store has one read port, and is then presented for its
// handshake. A new request is accepted only after every item of the previous
// one has been taken. When m_tready is low the current item is held.
// Reset clears configuration to defaults and drops any outstanding request;
// the reassembly store is not cleared. Configuration writes take effect at once.
module isotp_obd_request_receiver_top import iorr_pkg::*; #(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // frame_can_id, byte_count, data_bytes, zero pad
    input  logic [1:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // target_can_id, message_length, chunk_data,
                                  // chunk_bytes, negative_reply, zero pad
    output logic [2:0]  m_tuser,  // result_kind
    output logic        m_tlast
);
    iorr_cmd_t  cmd;
    iorr_stat_t stat;
    logic [10:0] out_id;
    logic [11:0] out_len;
    logic [63:0] out_data;
    logic [3:0]  out_nb;
    logic        out_neg;

    iorr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    iorr_datapath #(.BUFFER_BYTES(BUFFER_BYTES)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_type   (s_tuser),
        .in_id     (s_tdata[10:0]),
        .in_cnt    (s_tdata[14:11]),
        .in_data   (s_tdata[78:15]),
        .cmd       (cmd),
        .stat      (stat),
        .out_kind  (m_tuser),
        .out_id    (out_id),
        .out_len   (out_len),
        .out_data  (out_data),
        .out_nb    (out_nb),
        .out_neg   (out_neg),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0, out_neg, out_nb, out_data, out_len, out_id};

    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request accepted while a result is pending");

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_CHUNK) |-> m_tlast)
        else $error("non-chunk result not marked last");

    a_chunk_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_CHUNK) |-> (out_nb != 4'd0 && out_nb <= 4'd8))
        else $error("chunk byte count out of range");

    a_chunk_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser == KIND_CHUNK && !m_tlast) |=> !s_tready)
        else $error("input reopened before the last chunk");
endmodule
